FILE: rtl/ttce_pkg.sv
// Shared types and constants for the text terminal cursor engine.
// No dependencies; imported by every module of the block.
package ttce_pkg;

    // Byte codes seen by the escape parser
    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
    localparam logic [7:0] BYTE_LF       = 8'h0A;
    localparam logic [7:0] BYTE_CR       = 8'h0D;
    localparam logic [7:0] BYTE_FINAL_LO = 8'h40;
    localparam logic [7:0] BYTE_FINAL_HI = 8'h7E;

    // Operations passed from parser to cursor unit
    typedef logic [1:0] t_op;
    localparam t_op OP_WR = 2'd0;
    localparam t_op OP_LF = 2'd1;
    localparam t_op OP_CR = 2'd2;

    // Result command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SCROLL = 1'b1;

    // Configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;
    localparam logic [6:0] ROWS_RESET = 7'd24;
    localparam logic [8:0] COLS_RESET = 9'd80;

    // Op queue depth
    localparam int QDEPTH = 4;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
    } t_qent;

    typedef struct packed {
        logic       cmd;
        logic [5:0] row;
        logic [7:0] col;
        logic [7:0] ch;
        logic       last;
    } t_result;

endpackage

FILE: rtl/text_terminal_cursor_engine.sv
// Top level of the text terminal cursor engine: config registers, parser, op queue, cursor unit.
// Depends on ttce_pkg, ttce_front, ttce_fifo, ttce_back.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | i_in_valid/o_in_ready  | i_data_byte
//  out     | output    | o_out_valid/i_out_ready| o_command o_cell_row o_cell_col
//          |           |                        | o_char_code o_last_result
//  cfg     | input     | i_cfg_we (no wait)     | i_cfg_index i_cfg_data
//
// One byte is taken per cycle while the op queue has room and the row pointers are not
// being re-reduced. In the cursor unit a write that wraps first runs a new-line step, then
// writes. Reset is synchronous, active low. A screen_rows write drops o_in_ready while the
// row pointers are re-reduced. A stalled output holds its result register; the queue
// absorbs input meanwhile.
module text_terminal_cursor_engine #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_data_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_command,
    output logic [5:0]                        o_cell_row,
    output logic [7:0]                        o_cell_col,
    output logic [7:0]                        o_char_code,
    output logic                              o_last_result,
    input  logic                              i_cfg_we,
    input  logic [ttce_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ttce_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ttce_pkg::*;

    logic [6:0] r_screen_rows;
    logic [8:0] r_screen_cols;
    logic       norm_start;
    logic       q_full;
    logic       q_valid;
    logic       q_push;
    logic       q_pop;
    logic       busy;
    t_qent      q_in;
    t_qent      q_out;
    t_result    res;

    assign norm_start = i_cfg_we && (i_cfg_index == REG_ROWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_rows <= ROWS_RESET;
            r_screen_cols <= COLS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROWS: r_screen_rows <= i_cfg_data[6:0];
                REG_COLS: r_screen_cols <= i_cfg_data[8:0];
                default:  ;
            endcase
        end
    end

    ttce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_full      (q_full),
        .i_busy      (busy),
        .o_push      (q_push),
        .o_ent       (q_in)
    );

    ttce_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    ttce_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_screen_rows (r_screen_rows),
        .i_screen_cols (r_screen_cols),
        .i_norm_start  (norm_start),
        .i_op_valid    (q_valid),
        .i_op          (q_out),
        .o_pop         (q_pop),
        .o_busy        (busy),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out         (res)
    );

    assign o_command     = res.cmd;
    assign o_cell_row    = res.row;
    assign o_cell_col    = res.col;
    assign o_char_code   = res.ch;
    assign o_last_result = res.last;

endmodule

FILE: rtl/ttce_front.sv
// Escape parser front end: accepts bytes, tracks parse mode, queues cursor ops.
// Depends on ttce_pkg.
module ttce_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_full,
    input  logic            i_busy,
    output logic            o_push,
    output ttce_pkg::t_qent o_ent
);
    import ttce_pkg::*;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_CSI    = 2'd2;

    logic [1:0] r_mode;
    logic [1:0] n_mode;
    logic       acc;
    logic       has_op;

    assign o_ready = !i_full && !i_busy;
    assign acc     = i_valid && o_ready;
    assign o_push  = acc && has_op;

    always_comb begin
        n_mode   = r_mode;
        has_op   = 1'b0;
        o_ent.ch = i_data_byte;
        o_ent.op = OP_WR;
        case (r_mode)
            MODE_ESC: begin
                n_mode = (i_data_byte == BYTE_LBRACKET) ? MODE_CSI : MODE_NORMAL;
            end
            MODE_CSI: begin
                if (i_data_byte inside {[BYTE_FINAL_LO:BYTE_FINAL_HI]}) begin
                    n_mode = MODE_NORMAL;
                end
            end
            default: begin
                // unused code 3 behaves as normal
                n_mode = MODE_NORMAL;
                if (i_data_byte == BYTE_ESC) begin
                    n_mode = MODE_ESC;
                end else if (i_data_byte == BYTE_LF) begin
                    has_op   = 1'b1;
                    o_ent.op = OP_LF;
                end else if (i_data_byte == BYTE_CR) begin
                    has_op   = 1'b1;
                    o_ent.op = OP_CR;
                end else begin
                    has_op   = 1'b1;
                    o_ent.op = OP_WR;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
        end else if (acc) begin
            r_mode <= n_mode;
        end
    end

endmodule

FILE: rtl/ttce_fifo.sv
// Short op queue between the parser and the cursor unit.
// Depends on ttce_pkg for the entry type.
module ttce_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ttce_pkg::t_qent i_data,
    output logic            o_full,
    output logic            o_valid,
    output ttce_pkg::t_qent o_data,
    input  logic            i_pop
);
    import ttce_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_qent              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/ttce_back.sv
// Cursor unit: executes queued ops, keeps cursor and top pointer, drives result register.
// Also holds the bit-serial reducer that re-normalizes row pointers after a rows write.
// Depends on ttce_pkg.
module ttce_back #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [6:0]        i_screen_rows,
    input  logic [8:0]        i_screen_cols,
    input  logic              i_norm_start,
    input  logic              i_op_valid,
    input  ttce_pkg::t_qent   i_op,
    output logic              o_pop,
    output logic              o_busy,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ttce_pkg::t_result o_out
);
    import ttce_pkg::*;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int RW    = ROW_W + 1;
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int CNT_W = $clog2(ROW_W + 1);

    logic [RW-1:0]    rows_eff;
    logic [CW-1:0]    cols_eff;

    logic [ROW_W-1:0] r_crow;
    logic [ROW_W-1:0] r_crow_m;
    logic [ROW_W-1:0] r_top;
    logic [ROW_W-1:0] r_top_m;
    logic [CW-1:0]    r_col;
    logic [CNT_W-1:0] r_cnt;
    logic [ROW_W-1:0] r_sh_top;
    logic [ROW_W-1:0] r_sh_crow;
    logic             r_out_valid;
    t_result          r_out;

    logic             busy;
    logic             out_free;
    logic             at_bottom;
    logic [RW-1:0]    top_inc;
    logic [ROW_W-1:0] top_next;
    logic [RW-1:0]    phys_sum;
    logic [RW-1:0]    phys;
    logic             wrap;
    logic             is_wr;
    logic             is_lf;
    logic             is_cr;
    logic             do_nl;
    logic             load;
    logic             col_clr;
    logic             col_inc;
    logic             row_inc;
    logic             scroll;
    t_result          n_res;
    logic [RW-1:0]    rn_top;
    logic [RW-1:0]    rn_crow;
    logic [RW-1:0]    rem_top;
    logic [RW-1:0]    rem_crow;

    // Clamp register values to 1..MAX
    always_comb begin
        if (i_screen_rows == 7'd0) begin
            rows_eff = RW'(1);
        end else if (32'(i_screen_rows) > 32'(MAX_ROWS)) begin
            rows_eff = RW'(MAX_ROWS);
        end else begin
            rows_eff = RW'(i_screen_rows);
        end
        if (i_screen_cols == 9'd0) begin
            cols_eff = CW'(1);
        end else if (32'(i_screen_cols) > 32'(MAX_COLS)) begin
            cols_eff = CW'(MAX_COLS);
        end else begin
            cols_eff = CW'(i_screen_cols);
        end
    end

    assign busy     = i_norm_start || (r_cnt != '0);
    assign o_busy   = busy;
    assign out_free = !r_out_valid || i_out_ready;

    // Raw row on the last row or past it counts as bottom
    assign at_bottom = ({1'b0, r_crow} + RW'(1)) >= rows_eff;
    assign top_inc   = {1'b0, r_top_m} + RW'(1);
    assign top_next  = (top_inc == rows_eff) ? '0 : top_inc[ROW_W-1:0];
    // Both terms are below rows, so one subtract reduces the sum
    assign phys_sum  = {1'b0, r_top_m} + {1'b0, r_crow_m};
    assign phys      = (phys_sum >= rows_eff) ? (phys_sum - rows_eff) : phys_sum;
    assign wrap      = (r_col >= cols_eff);

    assign is_wr = (i_op.op == OP_WR);
    assign is_lf = (i_op.op == OP_LF);
    assign is_cr = (i_op.op == OP_CR);
    assign do_nl = is_lf || (is_wr && wrap);

    // A wrapping write first runs a new-line step without popping,
    // then comes back with column 0 and writes.
    always_comb begin
        o_pop   = 1'b0;
        load    = 1'b0;
        col_clr = 1'b0;
        col_inc = 1'b0;
        row_inc = 1'b0;
        scroll  = 1'b0;
        n_res   = '0;
        if (i_op_valid && !busy) begin
            if (do_nl) begin
                if (at_bottom) begin
                    if (out_free) begin
                        scroll     = 1'b1;
                        load       = 1'b1;
                        col_clr    = 1'b1;
                        o_pop      = is_lf;
                        n_res.cmd  = CMD_SCROLL;
                        n_res.row  = 6'(r_top_m);
                        n_res.last = is_lf;
                    end
                end else begin
                    row_inc = 1'b1;
                    col_clr = 1'b1;
                    o_pop   = is_lf;
                end
            end else if (is_cr) begin
                col_clr = 1'b1;
                o_pop   = 1'b1;
            end else if (is_wr) begin
                if (out_free) begin
                    load       = 1'b1;
                    col_inc    = 1'b1;
                    o_pop      = 1'b1;
                    n_res.cmd  = CMD_WRITE;
                    n_res.row  = 6'(phys[ROW_W-1:0]);
                    n_res.col  = 8'(r_col);
                    n_res.ch   = i_op.ch;
                    n_res.last = 1'b1;
                end
            end else begin
                o_pop = 1'b1;
            end
        end
    end

    // One remainder step per cycle, MSB first
    always_comb begin
        rn_top  = {r_top_m, r_sh_top[ROW_W-1]};
        rn_crow = {r_crow_m, r_sh_crow[ROW_W-1]};
        rem_top  = (rn_top >= rows_eff) ? (rn_top - rows_eff) : rn_top;
        rem_crow = (rn_crow >= rows_eff) ? (rn_crow - rows_eff) : rn_crow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crow      <= '0;
            r_crow_m    <= '0;
            r_top       <= '0;
            r_top_m     <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (col_clr) begin
                r_col <= '0;
            end else if (col_inc) begin
                r_col <= r_col + CW'(1);
            end
            if (row_inc) begin
                r_crow   <= r_crow + ROW_W'(1);
                r_crow_m <= r_crow_m + ROW_W'(1);
            end
            if (scroll) begin
                r_top   <= top_next;
                r_top_m <= top_next;
            end
            if (i_norm_start) begin
                r_cnt    <= CNT_W'(ROW_W);
                r_top_m  <= '0;
                r_crow_m <= '0;
            end else if (r_cnt != '0) begin
                r_cnt    <= r_cnt - CNT_W'(1);
                r_top_m  <= rem_top[ROW_W-1:0];
                r_crow_m <= rem_crow[ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_norm_start) begin
            r_sh_top  <= r_top;
            r_sh_crow <= r_crow;
        end else if (r_cnt != '0) begin
            r_sh_top  <= r_sh_top << 1;
            r_sh_crow <= r_sh_crow << 1;
        end
        if (load) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_ptrs_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (({1'b0, r_top_m} < rows_eff) && ({1'b0, r_crow_m} < rows_eff)))
        else $error("normalized row pointer not below row count");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_pop)
        else $error("op consumed while pointers are being reduced");

    a_wrap_scroll_keeps_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (n_res.cmd == CMD_SCROLL) && !n_res.last) |-> !o_pop)
        else $error("wrap scroll dropped its pending write");

    a_write_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (n_res.cmd == CMD_WRITE)) |=> (r_col == ($past(r_col) + CW'(1))))
        else $error("column did not advance after a cell write");

endmodule

FILE: bench/text_terminal_cursor_engine_test.sv
// Self-checking bench for text_terminal_cursor_engine: escape parser, wrap, scroll.
// Depends on ttce_pkg and the RTL top; a local cursor model predicts every output word.
module text_terminal_cursor_engine_test;
    import ttce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS      = 64;
    localparam int MAX_COLS      = 256;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 200;

    typedef enum logic [1:0] {PM_NORMAL, PM_ESC, PM_CSI} t_parse_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_data_byte = 8'h00;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_command;
    logic [5:0]            o_cell_row;
    logic [7:0]            o_cell_col;
    logic [7:0]            o_char_code;
    logic                  o_last_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_ROWS;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // cursor model state and register copies
    t_parse_mode pmode = PM_NORMAL;
    int          cur_row = 0;
    int          cur_col = 0;
    int          top_ptr = 0;
    logic [6:0]  cfg_rows = ROWS_RESET;
    logic [8:0]  cfg_cols = COLS_RESET;
    t_result     cells_due[$];

    int fail_cnt = 0;
    int cycle_cnt = 0;
    int effective_cnt = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req_cnt = 0;
    int hold_seen = 0;
    int hold_left = 0;

    text_terminal_cursor_engine #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_command    (o_command),
        .o_cell_row   (o_cell_row),
        .o_cell_col   (o_cell_col),
        .o_char_code  (o_char_code),
        .o_last_result(o_last_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------- cursor model ----------------

    function automatic int row_count();
        int r = int'(cfg_rows);
        if (r == 0) r = 1;
        if (r > MAX_ROWS) r = MAX_ROWS;
        return r;
    endfunction

    task automatic advance_row(input bit is_last);
        int rows;
        int old_top;
        rows = row_count();
        cur_col = 0;
        if (cur_row + 1 < rows) begin
            cur_row++;
        end else begin
            old_top = top_ptr % rows;
            cells_due.insert(cells_due.size(),
                             t_result'{cmd: CMD_SCROLL, row: 6'(old_top), col: 8'd0,
                                       ch: 8'd0, last: is_last});
            top_ptr = (old_top + 1) % rows;
        end
    endtask

    task automatic terminal_step(input logic [7:0] b);
        int rows;
        int cols;
        cols = int'(cfg_cols);
        if (cols == 0) cols = 1;
        if (cols > MAX_COLS) cols = MAX_COLS;
        case (pmode)
            PM_ESC: begin
                pmode = (b == BYTE_LBRACKET) ? PM_CSI : PM_NORMAL;
            end
            PM_CSI: begin
                if (b >= BYTE_FINAL_LO && b <= BYTE_FINAL_HI) pmode = PM_NORMAL;
            end
            default: begin
                pmode = PM_NORMAL;
                if (b == BYTE_ESC) begin
                    pmode = PM_ESC;
                end else begin
                    effective_cnt++;
                    if (b == BYTE_LF) begin
                        advance_row(1'b1);
                    end else if (b == BYTE_CR) begin
                        cur_col = 0;
                    end else begin
                        // wrap first; the scroll word (if any) goes ahead of the write
                        if (cur_col >= cols) advance_row(1'b0);
                        rows = row_count();
                        cells_due.insert(cells_due.size(),
                                         t_result'{cmd: CMD_WRITE,
                                             row: 6'(((top_ptr % rows) + cur_row) % rows),
                                             col: 8'(cur_col), ch: b, last: 1'b1});
                        cur_col++;
                    end
                end
            end
        endcase
    endtask

    // ---------------- output side ----------------

    always @(posedge i_clk) begin
        if (hold_seen != hold_req_cnt) begin
            hold_seen = hold_req_cnt;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [8:0] want,
                               input logic [8:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : check_words
        t_result due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cells_due.size() == 0) begin
                $error("unexpected word: command %0d row %0d col %0d char %0d last %0d",
                       o_command, o_cell_row, o_cell_col, o_char_code, o_last_result);
                fail_cnt++;
            end else begin
                due = cells_due[0];
                cells_due.delete(0);
                check_field("command", 9'(due.cmd), 9'(o_command));
                check_field("cell_row", 9'(due.row), 9'(o_cell_row));
                check_field("cell_col", 9'(due.col), 9'(o_cell_col));
                check_field("char_code", 9'(due.ch), 9'(o_char_code));
                check_field("last_result", 9'(due.last), 9'(o_last_result));
            end
        end
    end

    // ---------------- input side ----------------

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        terminal_step(b);
    endtask

    // Stop offering, wait for every expected word, then let queued no-result bytes retire.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (cells_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_set(input logic [6:0] rows, input logic [8:0] cols);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_ROWS;
        i_cfg_data  <= CFG_DATA_W'(rows);
        @(posedge i_clk);
        cfg_rows = rows;
        i_cfg_index <= REG_COLS;
        i_cfg_data  <= cols;
        @(posedge i_clk);
        cfg_cols = cols;
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed text and control sequences, some broken ones and raw noise.
    task automatic send_sequence();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 50) begin
            n = $urandom_range(1, 8);
            repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end else if (kind < 60) begin
            send_byte(BYTE_LF);
        end else if (kind < 66) begin
            send_byte(BYTE_CR);
        end else if (kind < 70) begin
            send_byte(BYTE_CR);
            send_byte(BYTE_LF);
        end else if (kind < 80) begin
            send_byte(BYTE_ESC);
            send_byte(BYTE_LBRACKET);
            n = $urandom_range(0, 4);
            repeat (n) send_byte(8'($urandom_range(8'h20, 8'h3F)));
            send_byte(8'($urandom_range(BYTE_FINAL_LO, BYTE_FINAL_HI)));
        end else if (kind < 84) begin
            send_byte(BYTE_ESC);
            send_byte(8'($urandom_range(0, 255)));
        end else if (kind < 88) begin
            // unterminated or garbled control sequence
            send_byte(BYTE_ESC);
            send_byte(BYTE_LBRACKET);
            n = $urandom_range(1, 3);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_items(input int target);
        int start;
        start = effective_cnt;
        while (effective_cnt - start < target) send_sequence();
    endtask

    // ---------------- tests ----------------

    task automatic test_parser();
        logic [7:0] seq[$];
        seq = {8'h41, 8'h00, 8'hFF, BYTE_CR, BYTE_LF, BYTE_ESC, 8'h78,
               BYTE_ESC, BYTE_LBRACKET, 8'h3F, BYTE_FINAL_LO,
               BYTE_ESC, BYTE_LBRACKET, 8'h7F, BYTE_FINAL_HI, 8'h80};
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // 2x3 screen: plain wrap, wrap with scroll, line feed on the bottom row
    task automatic test_wrap_scroll();
        logic [7:0] seq[$];
        seq = {8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, BYTE_LF, BYTE_CR};
        drain();
        cfg_set(7'd2, 9'd3);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_register_extremes();
        logic [6:0] rows_list[4];
        logic [8:0] cols_list[4];
        rows_list = '{7'd1, 7'd64, 7'd0, 7'd127};
        cols_list = '{9'd1, 9'd256, 9'd0, 9'd511};
        tx_idle_pct  = 37;
        rx_stall_pct = 37;
        for (int i = 0; i < 4; i++) begin
            drain();
            cfg_set(rows_list[i], cols_list[i]);
            run_items(20);
        end
    endtask

    task automatic test_random_phases();
        int tx_list[4];
        int rx_list[4];
        tx_list = '{0, 85, 0, 37};
        rx_list = '{0, 0, 85, 37};
        for (int i = 0; i < 4; i++) begin
            drain();
            cfg_set(7'($urandom_range(1, 16)), 9'($urandom_range(1, 40)));
            tx_idle_pct  = tx_list[i];
            rx_stall_pct = rx_list[i];
            run_items(55);
        end
    endtask

    // receiver holds off long enough for the op queue to fill and stall the input
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req_cnt++;
        repeat (40) send_byte(8'($urandom_range(8'h20, 8'h7E)));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_parser();
        test_wrap_scroll();
        test_register_extremes();
        test_random_phases();
        test_backpressure();
        drain();
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ttce_pkg.sv
rtl/ttce_front.sv
rtl/ttce_fifo.sv
rtl/ttce_back.sv
rtl/text_terminal_cursor_engine.sv
bench/text_terminal_cursor_engine_test.sv
